[sv/b85dec_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the character-to-digit map of the base85 decoder.
// No dependencies; imported by every other file.
package b85dec_pkg;

    localparam int CHAR_W  = 8;
    localparam int WORD_W  = 32;
    localparam int DIGIT_W = 7;
    localparam int CNT_W   = 3;

    localparam logic [DIGIT_W-1:0] B85_BASE  = 7'd85;
    localparam logic [CNT_W-1:0]   GROUP_END = 3'd4;   // index of the fifth digit
    localparam logic [CHAR_W-1:0]  CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_END  = 8'h5D;  // ']'

    typedef struct packed {
        logic               bad;
        logic [DIGIT_W-1:0] digit;
    } digit_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_end;
        logic              bad_digit;
    } result_t;

    // RFC 1924 alphabet; characters outside it map to digit 0 with bad set
    function automatic digit_t char_to_digit(input logic [CHAR_W-1:0] c);
        digit_t r;
        r.bad   = 1'b0;
        r.digit = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.digit = DIGIT_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.digit = DIGIT_W'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.digit = DIGIT_W'(c - 8'h3D);
        end else begin
            case (c)
                8'h21: r.digit = 7'd62;
                8'h23: r.digit = 7'd63;
                8'h24: r.digit = 7'd64;
                8'h25: r.digit = 7'd65;
                8'h26: r.digit = 7'd66;
                8'h28: r.digit = 7'd67;
                8'h29: r.digit = 7'd68;
                8'h2A: r.digit = 7'd69;
                8'h2B: r.digit = 7'd70;
                8'h2D: r.digit = 7'd71;
                8'h3B: r.digit = 7'd72;
                8'h3C: r.digit = 7'd73;
                8'h3D: r.digit = 7'd74;
                8'h3E: r.digit = 7'd75;
                8'h3F: r.digit = 7'd76;
                8'h40: r.digit = 7'd77;
                8'h5E: r.digit = 7'd78;
                8'h5F: r.digit = 7'd79;
                8'h60: r.digit = 7'd80;
                8'h7B: r.digit = 7'd81;
                8'h7C: r.digit = 7'd82;
                8'h7D: r.digit = 7'd83;
                8'h7E: r.digit = 7'd84;
                default: r.bad = 1'b1;
            endcase
        end
        return r;
    endfunction

endpackage

[sv/b85dec_core.sv]
`timescale 1ns / 1ps
// Group accumulator: digit map, multiply-by-85 accumulate and group framing.
// Depends on b85dec_pkg.
module b85dec_core import b85dec_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              char_vld,
    input  logic [CHAR_W-1:0] char_in,
    output logic              res_vld,
    output result_t           res
);

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              err_reg, err_next;
    digit_t            dg;
    logic [WORD_W-1:0] mac;
    logic              err_acc;

    assign dg      = char_to_digit(char_in);
    assign mac     = acc_reg * WORD_W'(B85_BASE) + WORD_W'(dg.digit);
    assign err_acc = err_reg | dg.bad;

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        res_vld  = 1'b0;
        res      = '0;
        if (char_vld) begin
            if (cnt_reg == '0 && char_in == CHAR_NUL) begin
                // skipped between groups
            end else if (cnt_reg == '0 && char_in == CHAR_END) begin
                res_vld    = 1'b1;
                res.is_end = 1'b1;
                acc_next   = '0;
                err_next   = 1'b0;
            end else if (cnt_reg >= GROUP_END) begin
                res_vld       = 1'b1;
                res.word      = mac;
                res.bad_digit = err_acc;
                acc_next      = '0;
                cnt_next      = '0;
                err_next      = 1'b0;
            end else begin
                acc_next = mac;
                cnt_next = cnt_reg + 1'b1;
                err_next = err_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

endmodule

[sv/b85dec_obuf.sv]
`timescale 1ns / 1ps
// Output register plus skid entry; ready toward the input comes from a flop.
// Depends on b85dec_pkg.
module b85dec_obuf import b85dec_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    room,
    output logic    out_vld,
    input  logic    out_rdy,
    output result_t out_data
);

    logic    out_vld_reg, skid_vld_reg;
    result_t out_reg, skid_reg;
    logic    pop;

    assign pop      = out_vld_reg & out_rdy;
    assign room     = ~skid_vld_reg;
    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (pop) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (pop) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_reg <= push_data;
            end else begin
                skid_reg <= push_data;
            end
        end
    end

endmodule

[sv/base85_stream_decoder.sv]
`timescale 1ns / 1ps
// Base85 (RFC 1924 alphabet) stream decoder, one character per transaction.
// A completed result is registered into the output register, or into the skid entry while m_ is stalled.
// Throughput: one character per cycle while s_tready is high; the single 32x7 multiply-accumulate sets the path.
// Reset: synchronous on aresetn low; accumulator, digit count, error flag and
// output buffer clear, and s_tready is high in the first cycle after reset.
module base85_stream_decoder import b85dec_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input characters
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_in
    // decoded words
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,   // [31:0] word
    output logic              m_tlast,   // is_end: closing bracket marker, word is zero
    output logic              m_tuser    // [0] bad_digit
);

    logic    s_fire;
    logic    res_vld;
    result_t res;
    result_t out_data;

    // A transaction is taken whenever the skid entry is free, so the input
    // never waits on m_tready combinationally.
    assign s_fire = s_tvalid & s_tready;

    // Five characters build one word as acc*85+digit (mod 2^32). NUL between
    // groups is dropped; ']' between groups yields the end marker. A character
    // outside the alphabet counts as zero and flags the group's word.
    b85dec_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .char_vld (s_fire),
        .char_in  (s_tdata),
        .res_vld  (res_vld),
        .res      (res)
    );

    // Result register with one skid entry: holds a finished word while the
    // next character is accepted.
    b85dec_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_vld),
        .push_data (res),
        .room      (s_tready),
        .out_vld   (m_tvalid),
        .out_rdy   (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data.word;
    assign m_tlast = out_data.is_end;
    assign m_tuser = out_data.bad_digit;

    // Input stalls only when both buffer entries hold results.
    a_stall_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no pending result");

    // The end marker carries a zero word and no error flag.
    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == '0 && !m_tuser))
        else $error("end marker with nonzero word or error flag");

    // A full buffer with no drain stays full.
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && !m_tready) |=> !s_tready)
        else $error("skid entry lost while output stalled");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for base85_stream_decoder: feeds characters, mirrors the decoder state and
// checks every decoded word and end marker against the mirror. Needs b85dec_pkg and the DUT.
module tb_top;
    import b85dec_pkg::*;

    localparam int DIGITS_PER_WORD = 5;
    localparam int ALPHA_SIZE      = 85;
    localparam int ITEMS_PER_PACE  = 325;
    localparam int SETTLE_CYCLES   = 10;

    // RFC 1924 alphabet, digit 0 in the top byte; the grave accent goes in as a byte
    localparam logic [8*ALPHA_SIZE-1:0] B85_CHARS = {
        "0123456789",
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "abcdefghijklmnopqrstuvwxyz",
        "!#$%&()*+-;<=>?@^_", 8'h60, "{|}~"
    };

    // traffic pacing, one per stretch of the run
    typedef enum logic [1:0] {
        PACE_FREE,        // neither side idles
        PACE_SRC_IDLE,    // sender idles with a chance of 56 in 100
        PACE_SINK_STALL,  // receiver stalls with a chance of 56 in 100
        PACE_BOTH         // both idle with a chance of 8 in 100
    } pace_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    pace_t             pace = PACE_FREE;
    logic [CHAR_W-1:0] char_q[$];     // characters waiting to be sent
    result_t           word_q[$];     // decoded words still owed by the DUT
    int                mismatches = 0;

    // mirror of the decoder state
    logic [WORD_W-1:0] acc_mirror = '0;
    logic [CNT_W-1:0]  cnt_mirror = '0;
    logic              bad_mirror = 1'b0;

    base85_stream_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic logic [CHAR_W-1:0] alpha_char(input int idx);
        return B85_CHARS[8*(ALPHA_SIZE-1-idx) +: 8];
    endfunction

    // Advance the mirror by one accepted character; queue the word it completes, if any.
    task automatic decode_char(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        logic               miss;
        result_t            r;
        if (cnt_mirror == 0 && c == CHAR_NUL) begin
            // padding between groups, dropped silently
        end else if (cnt_mirror == 0 && c == CHAR_END) begin
            r.word      = '0;
            r.is_end    = 1'b1;
            r.bad_digit = 1'b0;
            word_q.push_back(r);
            acc_mirror = '0;
            bad_mirror = 1'b0;
        end else begin
            d    = '0;
            miss = 1'b1;
            for (int i = 0; i < ALPHA_SIZE; i++) begin
                if (alpha_char(i) == c) begin
                    d    = DIGIT_W'(i);
                    miss = 1'b0;
                end
            end
            // wraps modulo 2^32 at the accumulator width
            acc_mirror = acc_mirror * WORD_W'(ALPHA_SIZE) + WORD_W'(d);
            bad_mirror = bad_mirror | miss;
            if (cnt_mirror == CNT_W'(DIGITS_PER_WORD - 1)) begin
                r.word      = acc_mirror;
                r.is_end    = 1'b0;
                r.bad_digit = bad_mirror;
                word_q.push_back(r);
                acc_mirror = '0;
                cnt_mirror = '0;
                bad_mirror = 1'b0;
            end else begin
                cnt_mirror = cnt_mirror + 1'b1;
            end
        end
    endtask

    function automatic logic src_idle();
        int roll;
        roll = $urandom_range(0, 99);
        return (pace == PACE_SRC_IDLE && roll < 56) || (pace == PACE_BOTH && roll < 8);
    endfunction

    function automatic logic sink_stall();
        int roll;
        roll = $urandom_range(0, 99);
        return (pace == PACE_SINK_STALL && roll < 56) || (pace == PACE_BOTH && roll < 8);
    endfunction

    // Character driver: valid holds until the transaction completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (char_q.size() != 0 && !src_idle()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Word monitor: compares each transaction with the oldest owed word.
    always @(posedge aclk) begin : word_monitor
        result_t due;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (word_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected word %h is_end %b bad_digit %b",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                    end
                end else begin
                    due = word_q.pop_front();
                    if (m_tdata !== due.word || m_tlast !== due.is_end ||
                        m_tuser !== due.bad_digit) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: word %h/%h is_end %b/%b bad_digit %b/%b (exp/got)",
                                     $realtime, due.word, m_tdata, due.is_end, m_tlast,
                                     due.bad_digit, m_tuser);
                        end
                    end
                end
            end
            m_tready <= !sink_stall();
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            char_q.push_back(s[i]);
        end
    endtask

    initial begin
        int                produced;
        int                kind;
        logic [CHAR_W-1:0] c;
        while (!aresetn) @(negedge aclk);
        @(negedge aclk);
        for (int p = 0; p < 4; p++) begin
            pace = pace_t'(p);
            if (pace == PACE_FREE) begin
                push_text("00000");             // all-zero word
                char_q.push_back(CHAR_NUL);     // padding between groups
                push_text("~~~~~");             // largest digits, accumulator wraps
                char_q.push_back(CHAR_END);     // end marker between groups
                push_text("0");
                char_q.push_back(CHAR_NUL);     // NUL inside a group is a bad digit
                char_q.push_back(CHAR_END);     // so is the bracket
                char_q.push_back(8'hFF);
                push_text("~");
                char_q.push_back(CHAR_NUL);
                push_text("!z9A");
                char_q.push_back(8'h80);        // bad digit in the last position
            end
            produced = 0;
            while (produced < ITEMS_PER_PACE) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    // well-formed group, now and then with a stray byte in it
                    for (int k = 0; k < DIGITS_PER_WORD; k++) begin
                        if ($urandom_range(0, 49) == 0) begin
                            c = CHAR_W'($urandom_range(0, 255));
                        end else begin
                            c = alpha_char($urandom_range(0, ALPHA_SIZE - 1));
                        end
                        char_q.push_back(c);
                    end
                    produced += DIGITS_PER_WORD;
                end else if (kind < 80) begin
                    char_q.push_back(CHAR_NUL);
                end else if (kind < 88) begin
                    char_q.push_back(CHAR_END);
                    produced++;
                end else begin
                    char_q.push_back(CHAR_W'($urandom_range(0, 255)));
                    produced++;
                end
            end
            // drain the stream, then hold the sender until every word is out
            while (char_q.size() != 0 || s_tvalid) @(negedge aclk);
            while (word_q.size() != 0) @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && word_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/b85dec_pkg.sv
sv/b85dec_core.sv
sv/b85dec_obuf.sv
sv/base85_stream_decoder.sv
sim/tb_top.sv
